>>> src/sxfb_pkg.sv
// sxfb_pkg: shared types and constants for the sprite XOR framebuffer.
// Used by the front, command queue, back end and top level; no dependencies.

package sxfb_pkg;

   // opcode field codes
   localparam logic OP_CLEAR = 1'b0;
   localparam logic OP_DRAW  = 1'b1;

   // widest screen the block supports
   localparam int MAX_COLS  = 64;
   localparam int MAX_ROW_W = 6;

   // sprite pattern width
   localparam int PATTERN_BITS = 8;

   // entries in the queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // classified command handed from front to back
   typedef struct packed {
      logic                 is_clear;
      logic                 clipped;
      logic                 first_row;
      logic                 last_row;
      logic [MAX_ROW_W-1:0] row;
      logic [MAX_COLS-1:0]  mask;
   } cmd_type;

   // back end sequencer
   typedef enum logic {
      BK_IDLE,
      BK_MODIFY
   } back_state_type;

endpackage

>>> src/sxfb_front.sv
// sxfb_front: reduces coordinates, clips the row and builds the pixel mask.
// Depends on sxfb_pkg for cmd_type and the opcode codes.

module sxfb_front #(
   parameter int SCREEN_WIDTH  = 64,
   parameter int SCREEN_HEIGHT = 32
) (
   input  logic             req_opcode,
   input  logic [7:0]       req_x_pos,
   input  logic [7:0]       req_y_pos,
   input  logic [3:0]       req_row_offset,
   input  logic [7:0]       req_sprite_byte,
   input  logic             req_last_row,
   output sxfb_pkg::cmd_type cmd
);
   import sxfb_pkg::*;

   localparam int COL_W = $clog2(SCREEN_WIDTH);
   localparam int ROW_W = $clog2(SCREEN_HEIGHT);

   typedef logic [COL_W-1:0] xtab_type [256];
   typedef logic [ROW_W-1:0] ytab_type [256];

   // modulo tables, filled at elaboration
   function automatic xtab_type build_xtab();
      xtab_type t;
      for (int i = 0; i < 256; i++) begin
         t[i] = COL_W'(i % SCREEN_WIDTH);
      end
      return t;
   endfunction

   function automatic ytab_type build_ytab();
      ytab_type t;
      for (int i = 0; i < 256; i++) begin
         t[i] = ROW_W'(i % SCREEN_HEIGHT);
      end
      return t;
   endfunction

   localparam xtab_type XMOD = build_xtab();
   localparam ytab_type YMOD = build_ytab();

   logic [COL_W-1:0]    x_start;
   logic [7:0]          row_sum;
   logic [COL_W:0]      col;
   logic [MAX_COLS-1:0] mask;

   // start position and target row
   assign x_start = XMOD[req_x_pos];
   assign row_sum = 8'(YMOD[req_y_pos]) + 8'(req_row_offset);

   // pattern bits placed left to right, clipped at the right edge
   always_comb begin
      mask = '0;
      col  = '0;
      for (int j = 0; j < PATTERN_BITS; j++) begin
         col = (COL_W + 1)'(x_start) + (COL_W + 1)'(j);
         if (col < (COL_W + 1)'(SCREEN_WIDTH) && req_sprite_byte[PATTERN_BITS - 1 - j]) begin
            mask[col[COL_W-1:0]] = 1'b1;
         end
      end
   end

   // classified command
   always_comb begin
      cmd           = '0;
      cmd.is_clear  = (req_opcode == OP_CLEAR);
      cmd.clipped   = (row_sum >= 8'(SCREEN_HEIGHT));
      cmd.first_row = (req_row_offset == 4'd0);
      cmd.last_row  = req_last_row;
      cmd.row       = row_sum[MAX_ROW_W-1:0];
      cmd.mask      = mask;
   end

endmodule

>>> src/sxfb_cmd_queue.sv
// sxfb_cmd_queue: short register queue of commands between front and back.
// Depends on sxfb_pkg for cmd_type and the queue depth.

module sxfb_cmd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  sxfb_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output sxfb_pkg::cmd_type head_cmd,
   output logic              empty
);
   import sxfb_pkg::*;

   cmd_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign full     = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign head_cmd = entry_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

>>> src/sxfb_back.sv
// sxfb_back: framebuffer memory, read-modify-write sequencer, collision flag
// and result register. Depends on sxfb_pkg for cmd_type and the state type.

module sxfb_back #(
   parameter int SCREEN_WIDTH  = 64,
   parameter int SCREEN_HEIGHT = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  sxfb_pkg::cmd_type q_head,
   output logic              q_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic [4:0]        rsp_row_index,
   output logic [63:0]       rsp_row_pixels,
   output logic              rsp_row_written,
   output logic              rsp_collided,
   output logic              rsp_sprite_done
);
   import sxfb_pkg::*;

   localparam int ROW_W = $clog2(SCREEN_HEIGHT);

   back_state_type state_ff, state_in;

   logic [SCREEN_WIDTH-1:0]  frame_mem [SCREEN_HEIGHT];
   logic [SCREEN_HEIGHT-1:0] row_valid_ff;
   logic [SCREEN_WIDTH-1:0]  rd_data_ff;
   logic                     rd_valid_ff;
   cmd_type                  cur_ff;
   logic                     coll_ff, coll_in;
   logic                     out_valid_ff, out_valid_in;
   logic [4:0]               out_index_ff;
   logic [63:0]              out_pixels_ff;
   logic                     out_written_ff, out_coll_ff, out_done_ff;

   logic                     modify;
   logic                     wr_en;
   logic [ROW_W-1:0]         rd_addr, wr_addr;
   logic [SCREEN_WIDTH-1:0]  old_row, new_row, mask;
   logic                     hit;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (q_pop) begin
               state_in = BK_MODIFY;
            end
         end
         BK_MODIFY: begin
            state_in = BK_IDLE;
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // sequencer outputs: take a command only when the result slot will be free
   always_comb begin
      q_pop  = 1'b0;
      modify = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            q_pop = !q_empty && (!out_valid_ff || rsp_pop);
         end
         BK_MODIFY: begin
            modify = 1'b1;
         end
         default: begin
            q_pop  = 1'b0;
            modify = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // memory read at issue, write in the modify cycle
   assign rd_addr = q_head.row[ROW_W-1:0];
   assign wr_addr = cur_ff.row[ROW_W-1:0];
   assign wr_en   = modify && !cur_ff.is_clear && !cur_ff.clipped;

   always_ff @(posedge clock) begin
      if (q_pop) begin
         rd_data_ff <= frame_mem[rd_addr];
         cur_ff     <= q_head;
      end
      if (wr_en) begin
         frame_mem[wr_addr] <= new_row;
      end
   end

   // row valid bits: an invalid row reads as all pixels off
   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         if (q_pop) begin
            rd_valid_ff <= row_valid_ff[rd_addr];
         end
         if (modify && cur_ff.is_clear) begin
            row_valid_ff <= '0;
         end else if (wr_en) begin
            row_valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   // XOR update and collision
   assign mask    = cur_ff.mask[SCREEN_WIDTH-1:0];
   assign old_row = rd_valid_ff ? rd_data_ff : '0;
   assign new_row = old_row ^ mask;
   assign hit     = !cur_ff.clipped && ((old_row & mask) != '0);

   always_comb begin
      coll_in = coll_ff;
      if (modify) begin
         if (cur_ff.is_clear) begin
            coll_in = 1'b0;
         end else begin
            coll_in = (cur_ff.first_row ? 1'b0 : coll_ff) | hit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coll_ff <= 1'b0;
      end else begin
         coll_ff <= coll_in;
      end
   end

   // result register
   always_comb begin
      out_valid_in = out_valid_ff;
      if (modify) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (modify) begin
         if (cur_ff.is_clear) begin
            out_index_ff   <= '0;
            out_pixels_ff  <= '0;
            out_written_ff <= 1'b0;
            out_coll_ff    <= 1'b0;
            out_done_ff    <= 1'b0;
         end else if (cur_ff.clipped) begin
            out_index_ff   <= '0;
            out_pixels_ff  <= '0;
            out_written_ff <= 1'b0;
            out_coll_ff    <= coll_in;
            out_done_ff    <= cur_ff.last_row;
         end else begin
            out_index_ff   <= cur_ff.row[4:0];
            out_pixels_ff  <= 64'(new_row);
            out_written_ff <= 1'b1;
            out_coll_ff    <= coll_in;
            out_done_ff    <= cur_ff.last_row;
         end
      end
   end

   assign rsp_empty       = !out_valid_ff;
   assign rsp_row_index   = out_index_ff;
   assign rsp_row_pixels  = out_pixels_ff;
   assign rsp_row_written = out_written_ff;
   assign rsp_collided    = out_coll_ff;
   assign rsp_sprite_done = out_done_ff;

`ifndef SYNTHESIS
   // the result slot is free whenever a command is being applied
   a_slot_free: assert property (@(posedge clock) disable iff (reset)
      state_ff == BK_MODIFY |-> !out_valid_ff)
      else $error("result slot busy during modify");

   // a clear wipes every row and the collision flag
   a_clear_wipes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_MODIFY && cur_ff.is_clear) |=> (row_valid_ff == '0 && !coll_ff))
      else $error("clear left state behind");

   // clipped rows are never written
   a_clip_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_MODIFY && cur_ff.clipped) |-> !wr_en)
      else $error("clipped row written");

   // a command is only taken from the queue when idle
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (state_ff == BK_IDLE && !q_empty))
      else $error("queue popped outside idle");
`endif

endmodule

>>> src/sprite_xor_framebuffer_unit.sv
// Sprite XOR framebuffer: command front end, command queue and
// read-modify-write back end. Depends on sxfb_pkg and the sxfb_* modules.
//
// Usage:
//   Request side is a queue: drive req_* fields with req_push; a beat is
//   taken at a clock edge where req_push is high and req_full is low.
//   Opcode clear wipes the screen; opcode draw XORs one 8-pixel sprite row.
//   Response side is a queue: while rsp_empty is low the oldest result sits
//   on rsp_*; it is taken at an edge where rsp_pop is high.
//   Exactly one response beat per request beat, in order.
// Timing:
//   A taken request passes the command queue, then the back end reads its
//   row from the framebuffer memory and writes it back into memory and the
//   result register; the back end takes the next command only after that.
//   A two-entry queue separates front and back, so requests keep being
//   taken while a finished result waits.
// Reset (synchronous, active high) clears the framebuffer at once through
//   per-row valid bits, clears the collision flag and empties both queues.
// When rsp_pop is held low the result holds, the back end waits, the
//   command queue fills and req_full rises.

module sprite_xor_framebuffer_unit #(
   parameter int SCREEN_WIDTH  = 64,
   parameter int SCREEN_HEIGHT = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic        req_opcode,
   input  logic [7:0]  req_x_pos,
   input  logic [7:0]  req_y_pos,
   input  logic [3:0]  req_row_offset,
   input  logic [7:0]  req_sprite_byte,
   input  logic        req_last_row,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [4:0]  rsp_row_index,
   output logic [63:0] rsp_row_pixels,
   output logic        rsp_row_written,
   output logic        rsp_collided,
   output logic        rsp_sprite_done
);
   import sxfb_pkg::*;

   cmd_type front_cmd;
   cmd_type head_cmd;
   logic    q_empty;
   logic    q_pop;

   // classify the incoming beat
   sxfb_front #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_front (
      .req_opcode      (req_opcode),
      .req_x_pos       (req_x_pos),
      .req_y_pos       (req_y_pos),
      .req_row_offset  (req_row_offset),
      .req_sprite_byte (req_sprite_byte),
      .req_last_row    (req_last_row),
      .cmd             (front_cmd)
   );

   // decoupling queue
   sxfb_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (req_push),
      .push_cmd (front_cmd),
      .full     (req_full),
      .pop      (q_pop),
      .head_cmd (head_cmd),
      .empty    (q_empty)
   );

   // framebuffer update and results
   sxfb_back #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_head          (head_cmd),
      .q_pop           (q_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_row_index   (rsp_row_index),
      .rsp_row_pixels  (rsp_row_pixels),
      .rsp_row_written (rsp_row_written),
      .rsp_collided    (rsp_collided),
      .rsp_sprite_done (rsp_sprite_done)
   );

endmodule

>>> tb/sv/tb_sprite_xor_framebuffer_unit.sv
// Self-checking testbench for sprite_xor_framebuffer_unit: directed and random
// sprite rows and clears, checked against a behavioral framebuffer predictor.
// Depends on sxfb_pkg and the sprite_xor_framebuffer_unit RTL.

module tb_sprite_xor_framebuffer_unit;
   import sxfb_pkg::*;

   localparam int SCREEN_W      = 64;
   localparam int SCREEN_H      = 32;
   localparam int RANDOM_ITEMS  = 1350;
   localparam int HOLD_AT       = 300;
   localparam int HOLD_CYCLES   = 200;
   localparam int DRAIN_CYCLES  = 10;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int REPORT_MAX    = 10;

   // one request beat
   typedef struct {
      logic       opcode;
      logic [7:0] x_pos;
      logic [7:0] y_pos;
      logic [3:0] row_offset;
      logic [7:0] sprite_byte;
      logic       last_row;
   } sprite_cmd_type;

   // one response beat
   typedef struct {
      logic [4:0]  row_index;
      logic [63:0] row_pixels;
      logic        row_written;
      logic        collided;
      logic        sprite_done;
   } row_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic        req_opcode = 1'b0;
   logic [7:0]  req_x_pos = '0;
   logic [7:0]  req_y_pos = '0;
   logic [3:0]  req_row_offset = '0;
   logic [7:0]  req_sprite_byte = '0;
   logic        req_last_row = 1'b0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [4:0]  rsp_row_index;
   logic [63:0] rsp_row_pixels;
   logic        rsp_row_written;
   logic        rsp_collided;
   logic        rsp_sprite_done;

   // predictor state: shadow framebuffer and collision flag
   logic [63:0] shadow_screen [SCREEN_H];
   logic        shadow_collision = 1'b0;

   sprite_cmd_type sprite_cmds[$];
   sprite_cmd_type cur_cmd;
   row_result_type predicted_rows[$];

   int accepted_count = 0;
   int result_count   = 0;
   int mismatch_count = 0;
   int send_gap       = 0;
   int recv_wait      = 0;

   sprite_xor_framebuffer_unit DUT (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_opcode      (req_opcode),
      .req_x_pos       (req_x_pos),
      .req_y_pos       (req_y_pos),
      .req_row_offset  (req_row_offset),
      .req_sprite_byte (req_sprite_byte),
      .req_last_row    (req_last_row),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_row_index   (rsp_row_index),
      .rsp_row_pixels  (rsp_row_pixels),
      .rsp_row_written (rsp_row_written),
      .rsp_collided    (rsp_collided),
      .rsp_sprite_done (rsp_sprite_done)
   );

   always #10 clock = ~clock;

   initial begin
      foreach (shadow_screen[i]) shadow_screen[i] = '0;
   end

   // XOR one sprite row into the shadow screen, or wipe it on a clear
   function automatic row_result_type xor_row_into_screen(sprite_cmd_type c);
      row_result_type r;
      int          col_x;
      int          row;
      int          col;
      logic [63:0] mask;
      r = '{default: '0};
      if (c.opcode == OP_CLEAR) begin
         foreach (shadow_screen[i]) shadow_screen[i] = '0;
         shadow_collision = 1'b0;
         return r;
      end
      if (c.row_offset == 4'd0) shadow_collision = 1'b0;
      col_x = int'(c.x_pos) % SCREEN_W;
      row   = (int'(c.y_pos) % SCREEN_H) + int'(c.row_offset);
      if (row >= SCREEN_H) begin
         // below the bottom edge: nothing drawn
         r.collided    = shadow_collision;
         r.sprite_done = c.last_row;
         return r;
      end
      mask = '0;
      for (int j = 0; j < PATTERN_BITS; j++) begin
         col = col_x + j;
         if (col < SCREEN_W && c.sprite_byte[PATTERN_BITS-1-j]) mask[col] = 1'b1;
      end
      if ((shadow_screen[row] & mask) != '0) shadow_collision = 1'b1;
      shadow_screen[row] = shadow_screen[row] ^ mask;
      r.row_index   = row[4:0];
      r.row_pixels  = shadow_screen[row];
      r.row_written = 1'b1;
      r.collided    = shadow_collision;
      r.sprite_done = c.last_row;
      return r;
   endfunction

   task automatic push_cmd(logic op, logic [7:0] x, logic [7:0] y, logic [3:0] off,
                           logic [7:0] pat, logic last);
      sprite_cmd_type c;
      c.opcode      = op;
      c.x_pos       = x;
      c.y_pos       = y;
      c.row_offset  = off;
      c.sprite_byte = pat;
      c.last_row    = last;
      sprite_cmds.push_back(c);
   endtask

   // sender: a random gap before each beat, with calm stretches of back-to-back beats
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_push && !req_full) begin
            predicted_rows.push_back(xor_row_into_screen(cur_cmd));
            accepted_count++;
            send_gap = ((accepted_count / 150) % 4 == 1) ? 0 : $urandom_range(0, 3);
         end
         if (!req_push || !req_full) begin
            if (send_gap > 0) begin
               req_push <= 1'b0;
               send_gap--;
            end else if (sprite_cmds.size() > 0) begin
               cur_cmd = sprite_cmds.pop_front();
               req_push        <= 1'b1;
               req_opcode      <= cur_cmd.opcode;
               req_x_pos       <= cur_cmd.x_pos;
               req_y_pos       <= cur_cmd.y_pos;
               req_row_offset  <= cur_cmd.row_offset;
               req_sprite_byte <= cur_cmd.sprite_byte;
               req_last_row    <= cur_cmd.last_row;
            end else begin
               req_push <= 1'b0;
            end
         end
      end
   end

   // receiver: random pop stalls, one long hold-off to back up the block
   always @(posedge clock) begin
      row_result_type exp_row;
      if (reset) begin
         rsp_pop <= 1'b0;
         recv_wait = 0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            result_count++;
            if (predicted_rows.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX)
                  $display("ERROR: unexpected result row=%0d pixels=%h", rsp_row_index,
                           rsp_row_pixels);
            end else begin
               exp_row = predicted_rows.pop_front();
               if (rsp_row_index !== exp_row.row_index ||
                   rsp_row_pixels !== exp_row.row_pixels ||
                   rsp_row_written !== exp_row.row_written ||
                   rsp_collided !== exp_row.collided ||
                   rsp_sprite_done !== exp_row.sprite_done) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_MAX)
                     $display("ERROR: beat %0d exp row=%0d pix=%h wr=%b col=%b done=%b, %s",
                              result_count, exp_row.row_index, exp_row.row_pixels,
                              exp_row.row_written, exp_row.collided, exp_row.sprite_done,
                              $sformatf("got row=%0d pix=%h wr=%b col=%b done=%b",
                                        rsp_row_index, rsp_row_pixels, rsp_row_written,
                                        rsp_collided, rsp_sprite_done));
               end
            end
            recv_wait = ((result_count / 150) % 4 == 2) ? 0 : $urandom_range(0, 3);
            if (result_count == HOLD_AT) recv_wait = HOLD_CYCLES;
         end
         if (!(rsp_pop && rsp_empty)) begin
            if (recv_wait > 0) begin
               rsp_pop <= 1'b0;
               recv_wait--;
            end else begin
               rsp_pop <= 1'b1;
            end
         end
      end
   end

   // stimulus, then wait for the drain and report
   initial begin
      int          pick;
      int          len;
      int          cycles;
      logic [7:0]  sx;
      logic [7:0]  sy;
      logic [7:0]  pat;
      logic [7:0]  prev_bytes [16];
      int          prev_len;
      logic [7:0]  prev_x;
      logic [7:0]  prev_y;
      logic        redraw;

      // directed part
      push_cmd(OP_CLEAR, 8'hFF, 8'hFF, 4'hF, 8'hFF, 1'b1);   // clear with all fields high
      push_cmd(OP_DRAW, 8'd0, 8'd0, 4'd0, 8'hFF, 1'b1);      // top-left corner
      push_cmd(OP_DRAW, 8'd0, 8'd0, 4'd0, 8'hF0, 1'b1);      // collision on redraw
      push_cmd(OP_DRAW, 8'd4, 8'd0, 4'd3, 8'h81, 1'b0);      // no first row: flag carried
      push_cmd(OP_DRAW, 8'd63, 8'd5, 4'd0, 8'hFF, 1'b0);     // only leftmost pixel fits
      push_cmd(OP_DRAW, 8'd60, 8'd5, 4'd1, 8'hAB, 1'b0);     // right-edge clip
      push_cmd(OP_DRAW, 8'd255, 8'd255, 4'd0, 8'h80, 1'b1);  // x, y wrap to 63, 31
      push_cmd(OP_DRAW, 8'd255, 8'd255, 4'd0, 8'h80, 1'b1);  // erase it: collision
      push_cmd(OP_DRAW, 8'd10, 8'd31, 4'd1, 8'hFF, 1'b1);    // just below bottom edge
      push_cmd(OP_DRAW, 8'd10, 8'd20, 4'd15, 8'h55, 1'b0);   // offset 15, clipped
      push_cmd(OP_DRAW, 8'd10, 8'd16, 4'd15, 8'h3C, 1'b1);   // offset 15, last row on screen
      push_cmd(OP_DRAW, 8'd33, 8'd12, 4'd0, 8'h00, 1'b1);    // empty pattern still drawn
      push_cmd(OP_DRAW, 8'd128, 8'd64, 4'd0, 8'h01, 1'b0);   // high bits of x and y drop
      push_cmd(OP_DRAW, 8'd200, 8'd100, 4'd2, 8'hC3, 1'b1);
      push_cmd(OP_CLEAR, 8'd0, 8'd0, 4'd0, 8'd0, 1'b0);      // clear drops collision
      push_cmd(OP_DRAW, 8'd0, 8'd0, 4'd5, 8'hFF, 1'b1);      // after clear, flag stays low

      // random part: mostly whole sprites, some redraws, clears and noise
      prev_len = 0;
      prev_x   = '0;
      prev_y   = '0;
      foreach (prev_bytes[i]) prev_bytes[i] = '0;
      while (sprite_cmds.size() < RANDOM_ITEMS + 16) begin
         pick = $urandom_range(0, 99);
         if (pick < 3) begin
            push_cmd(OP_CLEAR, 8'($urandom), 8'($urandom), 4'($urandom), 8'($urandom),
                     1'($urandom));
         end else if (pick < 15) begin
            push_cmd(1'($urandom), 8'($urandom), 8'($urandom), 4'($urandom),
                     8'($urandom), 1'($urandom));
         end else begin
            redraw = (prev_len > 0) && ($urandom_range(0, 3) == 0);
            if (redraw) begin
               len = prev_len;
               sx  = prev_x;
               sy  = prev_y;
            end else begin
               len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
               sx  = 8'($urandom);
               sy  = 8'($urandom);
            end
            for (int r = 0; r < len; r++) begin
               if (redraw) begin
                  pat = prev_bytes[r];
               end else begin
                  pick = $urandom_range(0, 15);
                  pat  = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom);
                  prev_bytes[r] = pat;
               end
               push_cmd(OP_DRAW, sx, sy, 4'(r), pat, r == len - 1);
            end
            prev_len = len;
            prev_x   = sx;
            prev_y   = sy;
         end
      end

      // reset
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // wait for all beats to be taken and answered
      cycles = 0;
      while (cycles < CYCLE_LIMIT &&
             !(sprite_cmds.size() == 0 && !req_push && predicted_rows.size() == 0)) begin
         @(negedge clock);
         cycles++;
      end
      if (cycles >= CYCLE_LIMIT) begin
         $display("ERROR: timeout after %0d cycles", cycles);
         $display("Simulation FAILED");
      end else begin
         repeat (DRAIN_CYCLES) @(negedge clock);
         if (predicted_rows.size() != 0) begin
            mismatch_count++;
            $display("ERROR: %0d results never arrived", predicted_rows.size());
         end
         if (mismatch_count == 0) begin
            $display("Simulation PASSED");
         end else begin
            $display("Simulation FAILED");
         end
      end
      $finish;
   end

endmodule

>>> files.f
src/sxfb_pkg.sv
src/sxfb_front.sv
src/sxfb_cmd_queue.sv
src/sxfb_back.sv
src/sprite_xor_framebuffer_unit.sv
tb/sv/tb_sprite_xor_framebuffer_unit.sv
